@@ hdl/hcb_pkg.sv @@
// Shared types and constants for the Huffman code builder.
package hcb_pkg;

  localparam int unsigned MaxSymbols = 64;
  localparam int unsigned LeafSpace  = 64;

  typedef logic [6:0]  node_t;
  typedef logic [21:0] nweight_t;
  typedef logic [63:0] code_t;
  typedef logic [5:0]  clen_t;

endpackage

@@ hdl/huffman_code_builder.sv @@
// Huffman code builder: leaf load, array min-heap tree build and code walk.
// Load: one word per cycle while idle; the word marked last starts the build.
// Build: seed the heap with the leaf indices and heapify it; each extract reads the top and last
// slots and sifts down, and each insert of a new parent sifts up. Walk: depth-first,
// stacking right children, one word per leaf via the output handshake; no input till done.
// Reset clears control state only; the RAMs hold no reset value.
module huffman_code_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          symbol_i,
  input  logic [15:0]         weight_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_symbol_o,
  output hcb_pkg::code_t      code_bits_o,
  output hcb_pkg::clen_t      code_length_o,
  output logic                final_code_o
);
  import hcb_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_HFY, S_CW, S_SD0, S_SD1, S_SD2, S_SD3,
    S_BLD, S_TK0, S_TK1, S_TK2, S_PUT0, S_PU1, S_PU2, S_PU3,
    S_WK, S_LF, S_ND, S_EMIT, S_POP
  } state_e;

  typedef enum logic [1:0] {RET_HFY, RET_A, RET_B, RET_ROOT} ret_e;

  localparam logic [6:0] MaxCnt = 7'(MaxSymbols);
  localparam node_t      LeafBase = node_t'(LeafSpace);

  state_e   state_q, state_d;
  ret_e     ret_q, ret_d;
  logic [6:0] loaded_q, loaded_d, cnt_q, cnt_d, idx_q, idx_d, sp_q, sp_d;
  logic [5:0] pos_q, pos_d, par_q, par_d;
  node_t    cn_q, cn_d, ln_q, ln_d, rn_q, rn_d, a_q, a_d, b_q, b_d, p_q, p_d;
  nweight_t cw_q, cw_d, lw_q, lw_d, wa_q, wa_d, wb_q, wb_d, pw_q, pw_d;
  node_t    cur_q, cur_d;
  code_t    code_q, code_d;
  clen_t    len_q, len_d;
  logic     ov_q, ov_d, ofin_q, ofin_d;
  logic [7:0] osym_q, osym_d;
  code_t    ocode_q, ocode_d;
  clen_t    olen_q, olen_d;

  // RAMs
  nweight_t wt_mem [127];
  node_t    hp_mem [64];
  node_t    lc_mem [63];
  node_t    rc_mem [63];
  logic [7:0] ls_mem [64];
  logic [76:0] st_mem [64];

  logic       wt_we, hp_we, ch_we, ls_we, st_we;
  node_t      wt_waddr, wt_raddr;
  nweight_t   wt_wdata, wt_rd;
  logic [5:0] hp_waddr, hp_raddr, ch_addr, ls_addr, st_waddr, st_raddr;
  node_t      hp_wdata, hp_rd, lc_rd, rc_rd;
  logic [7:0] ls_rd;
  logic [76:0] st_wdata, st_rd;

  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
    wt_rd <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) hp_mem[hp_waddr] <= hp_wdata;
    hp_rd <= hp_mem[hp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      lc_mem[par_q] <= a_q;
      rc_mem[par_q] <= b_q;
    end
    lc_rd <= lc_mem[ch_addr];
    rc_rd <= rc_mem[ch_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[loaded_q[5:0]] <= symbol_i;
    ls_rd <= ls_mem[ls_addr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rd <= st_mem[st_raddr];
  end

  logic [6:0] l_w, r_w;
  logic       room_w;
  assign l_w    = {pos_q, 1'b1};
  assign r_w    = l_w + 7'd1;
  assign room_w = loaded_q < MaxCnt;

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = ov_q;
  assign out_symbol_o  = osym_q;
  assign code_bits_o   = ocode_q;
  assign code_length_o = olen_q;
  assign final_code_o  = ofin_q;

  always_comb begin
    logic [5:0] best;
    node_t      bn;
    nweight_t   bw;
    nweight_t   sum;
    state_d = state_q; ret_d = ret_q;
    loaded_d = loaded_q; cnt_d = cnt_q; idx_d = idx_q; sp_d = sp_q;
    pos_d = pos_q; par_d = par_q;
    cn_d = cn_q; ln_d = ln_q; rn_d = rn_q; a_d = a_q; b_d = b_q; p_d = p_q;
    cw_d = cw_q; lw_d = lw_q; wa_d = wa_q; wb_d = wb_q; pw_d = pw_q;
    cur_d = cur_q; code_d = code_q; len_d = len_q;
    ov_d = ov_q; ofin_d = ofin_q; osym_d = osym_q; ocode_d = ocode_q; olen_d = olen_q;
    wt_we = 1'b0; wt_waddr = {1'b0, loaded_q[5:0]}; wt_wdata = {6'd0, weight_i};
    wt_raddr = cn_q;
    hp_we = 1'b0; hp_waddr = pos_q; hp_wdata = cn_q; hp_raddr = 6'd0;
    ch_we = 1'b0; ch_addr = cur_q[5:0];
    ls_we = 1'b0; ls_addr = cur_q[5:0];
    st_we = 1'b0; st_waddr = sp_q[5:0];
    st_wdata = {rc_rd, code_q[62:0], 1'b1, len_q + 6'd1};
    st_raddr = sp_q[5:0] - 6'd1;
    best = pos_q; bn = cn_q; bw = cw_q;
    sum = wa_q + wb_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (room_w) begin
            wt_we = 1'b1;
            ls_we = 1'b1;
            loaded_d = loaded_q + 7'd1;
          end
          if (last_i) begin
            idx_d = 7'd0;
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        hp_we = 1'b1;
        hp_waddr = idx_q[5:0];
        hp_wdata = idx_q;
        idx_d = idx_q + 7'd1;
        if (idx_q + 7'd1 == loaded_q) begin
          cnt_d = loaded_q;
          idx_d = loaded_q >> 1;
          state_d = S_HFY;
        end
      end
      S_HFY: begin
        if (idx_q == 7'd0) begin
          state_d = S_BLD;
        end else begin
          pos_d = idx_q[5:0] - 6'd1;
          cn_d = idx_q - 7'd1;
          wt_raddr = idx_q - 7'd1;
          idx_d = idx_q - 7'd1;
          ret_d = RET_HFY;
          state_d = S_CW;
        end
      end
      S_CW: begin
        cw_d = wt_rd;
        state_d = S_SD0;
      end
      S_SD0: begin
        if (l_w >= cnt_q) begin
          hp_we = 1'b1;
          state_d = S_HFY;
          case (ret_q)
            RET_A: begin
              ret_d = RET_B;
              state_d = S_TK0;
            end
            RET_B:    state_d = S_PUT0;
            RET_ROOT: begin
              cur_d = a_q;
              code_d = '0;
              len_d = '0;
              sp_d = 7'd0;
              state_d = S_WK;
            end
            default:  state_d = S_HFY;
          endcase
        end else begin
          hp_raddr = l_w[5:0];
          state_d = S_SD1;
        end
      end
      S_SD1: begin
        ln_d = hp_rd;
        wt_raddr = hp_rd;
        hp_raddr = r_w[5:0];
        state_d = S_SD2;
      end
      S_SD2: begin
        lw_d = wt_rd;
        rn_d = hp_rd;
        wt_raddr = hp_rd;
        state_d = S_SD3;
      end
      S_SD3: begin
        if (lw_q < cw_q) begin
          best = l_w[5:0]; bn = ln_q; bw = lw_q;
        end
        if (r_w < cnt_q && wt_rd < bw) begin
          best = r_w[5:0]; bn = rn_q;
        end
        hp_we = 1'b1;
        if (best == pos_q) begin
          state_d = S_SD0;
          pos_d = pos_q;
          // moving node settles here; reuse the done path of SD0
          hp_wdata = cn_q;
          case (ret_q)
            RET_A: begin
              ret_d = RET_B;
              state_d = S_TK0;
            end
            RET_B:    state_d = S_PUT0;
            RET_ROOT: begin
              cur_d = a_q;
              code_d = '0;
              len_d = '0;
              sp_d = 7'd0;
              state_d = S_WK;
            end
            default:  state_d = S_HFY;
          endcase
        end else begin
          hp_wdata = bn;
          pos_d = best;
          state_d = S_SD0;
        end
      end
      S_BLD: begin
        ret_d = (cnt_q > 7'd1) ? RET_A : RET_ROOT;
        state_d = S_TK0;
      end
      S_TK0: begin
        hp_raddr = 6'd0;
        state_d = S_TK1;
      end
      S_TK1: begin
        if (ret_q == RET_B) b_d = hp_rd;
        else a_d = hp_rd;
        wt_raddr = hp_rd;
        hp_raddr = cnt_q[5:0] - 6'd1;
        state_d = S_TK2;
      end
      S_TK2: begin
        if (ret_q == RET_B) wb_d = wt_rd;
        else wa_d = wt_rd;
        cn_d = hp_rd;
        wt_raddr = hp_rd;
        cnt_d = cnt_q - 7'd1;
        pos_d = 6'd0;
        state_d = S_CW;
      end
      S_PUT0: begin
        p_d = LeafBase + {1'b0, par_q};
        pw_d = sum;
        wt_we = 1'b1;
        wt_waddr = LeafBase + {1'b0, par_q};
        wt_wdata = sum;
        ch_we = 1'b1;
        par_d = par_q + 6'd1;
        pos_d = cnt_q[5:0];
        cnt_d = cnt_q + 7'd1;
        state_d = S_PU1;
      end
      S_PU1: begin
        if (pos_q == 6'd0) begin
          hp_we = 1'b1;
          hp_wdata = p_q;
          state_d = S_BLD;
        end else begin
          hp_raddr = (pos_q - 6'd1) >> 1;
          state_d = S_PU2;
        end
      end
      S_PU2: begin
        ln_d = hp_rd;
        wt_raddr = hp_rd;
        state_d = S_PU3;
      end
      S_PU3: begin
        hp_we = 1'b1;
        if (pw_q < wt_rd) begin
          hp_wdata = ln_q;
          pos_d = (pos_q - 6'd1) >> 1;
          state_d = S_PU1;
        end else begin
          hp_wdata = p_q;
          state_d = S_BLD;
        end
      end
      S_WK: begin
        ls_addr = cur_q[5:0];
        ch_addr = cur_q[5:0];
        state_d = cur_q[6] ? S_ND : S_LF;
      end
      S_ND: begin
        st_we = 1'b1;
        sp_d = sp_q + 7'd1;
        cur_d = lc_rd;
        code_d = {code_q[62:0], 1'b0};
        len_d = len_q + 6'd1;
        state_d = S_WK;
      end
      S_LF: begin
        ov_d = 1'b1;
        osym_d = ls_rd;
        ocode_d = code_q;
        olen_d = len_q;
        ofin_d = (sp_q == 7'd0);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (ofin_q) begin
            loaded_d = 7'd0;
            cnt_d = 7'd0;
            par_d = 6'd0;
            state_d = S_IDLE;
          end else begin
            sp_d = sp_q - 7'd1;
            state_d = S_POP;
          end
        end
      end
      S_POP: begin
        cur_d = st_rd[76:70];
        code_d = st_rd[69:6];
        len_d = st_rd[5:0];
        state_d = S_WK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= RET_HFY;
      loaded_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
      sp_q <= '0;
      par_q <= '0;
      ov_q <= 1'b0;
      ofin_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      loaded_q <= loaded_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
      sp_q <= sp_d;
      par_q <= par_d;
      ov_q <= ov_d;
      ofin_q <= ofin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    cn_q <= cn_d; ln_q <= ln_d; rn_q <= rn_d;
    a_q <= a_d; b_q <= b_d; p_q <= p_d;
    cw_q <= cw_d; lw_q <= lw_d; wa_q <= wa_d; wb_q <= wb_d; pw_q <= pw_d;
    cur_q <= cur_d; code_q <= code_d; len_q <= len_d;
    osym_q <= osym_d; ocode_q <= ocode_d; olen_q <= olen_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt && loaded_q <= MaxCnt)
    else $error("heap or leaf count out of range");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken during emission");
  a_final_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && final_code_o) |-> sp_q == 7'd0)
    else $error("final word with stack not empty");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && final_code_o) |=> (in_ready_o && loaded_q == 7'd0))
    else $error("block not idle after final word");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for the Huffman code builder: predicts codes per alphabet and checks each output word.
`timescale 1ns / 100ps

module tb_top;

  import hcb_pkg::*;

  typedef struct packed {
    logic [7:0] sym;
    code_t      bits;
    clen_t      len;
    logic       fin;
  } code_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  symbol_i;
  logic [15:0] weight_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_symbol_o;
  code_t       code_bits_o;
  clen_t       code_length_o;
  logic        final_code_o;

  huffman_code_builder u_dut (.*);

  // predictor state
  nweight_t   tree_weight [127];
  node_t      left_of [63];
  node_t      right_of [63];
  logic [7:0] leaf_sym [64];
  node_t      heap [64];
  int         heap_n;
  int         n_loaded;

  code_word_t expected_codes[$];
  int         err_cnt;
  logic       sink_busy;

  always #4 clk_i = ~clk_i;

  function automatic nweight_t slot_w(int pos);
    return tree_weight[heap[pos]];
  endfunction

  function automatic void sift_down(int pos);
    int best;
    int l;
    int r;
    node_t t;
    forever begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < heap_n && slot_w(l) < slot_w(best)) best = l;
      if (r < heap_n && slot_w(r) < slot_w(best)) best = r;
      if (best == pos) return;
      t = heap[best];
      heap[best] = heap[pos];
      heap[pos] = t;
      pos = best;
    end
  endfunction

  function automatic node_t pop_min();
    node_t top;
    top = heap[0];
    heap[0] = heap[heap_n - 1];
    heap_n--;
    sift_down(0);
    return top;
  endfunction

  function automatic void push_node(node_t nd);
    int i;
    nweight_t w;
    i = heap_n;
    w = tree_weight[nd];
    heap_n++;
    while (i != 0 && w < slot_w((i - 1) / 2)) begin
      heap[i] = heap[(i - 1) / 2];
      i = (i - 1) / 2;
    end
    heap[i] = nd;
  endfunction

  function automatic void predict_codes(logic [7:0] sym, logic [15:0] w, logic lst);
    int nparents;
    int sp;
    node_t a;
    node_t b;
    node_t nd;
    node_t stk [64];
    code_t cstk [64];
    clen_t lstk [64];
    code_word_t cw;
    int first_idx;
    if (n_loaded < MaxSymbols) begin
      leaf_sym[n_loaded] = sym;
      tree_weight[n_loaded] = nweight_t'(w);
      n_loaded++;
    end
    if (!lst) return;
    for (int i = 0; i < n_loaded; i++) heap[i] = node_t'(i);
    heap_n = n_loaded;
    for (int i = n_loaded / 2; i > 0; i--) sift_down(i - 1);
    nparents = 0;
    while (heap_n > 1 && nparents < 63) begin
      a = pop_min();
      b = pop_min();
      tree_weight[LeafSpace + nparents] = tree_weight[a] + tree_weight[b];
      left_of[nparents] = a;
      right_of[nparents] = b;
      push_node(node_t'(LeafSpace + nparents));
      nparents++;
    end
    stk[0] = pop_min();
    cstk[0] = '0;
    lstk[0] = '0;
    sp = 1;
    first_idx = expected_codes.size();
    while (sp > 0) begin
      sp--;
      nd = stk[sp];
      if (nd < LeafSpace) begin
        cw.sym = leaf_sym[nd];
        cw.bits = cstk[sp];
        cw.len = lstk[sp];
        cw.fin = 1'b0;
        expected_codes.push_back(cw);
      end else begin
        stk[sp] = right_of[nd - LeafSpace];
        cstk[sp+1] = cstk[sp] << 1;
        cstk[sp] = (cstk[sp] << 1) | 64'd1;
        lstk[sp] = lstk[sp] + 1'b1;
        lstk[sp+1] = lstk[sp];
        stk[sp+1] = left_of[nd - LeafSpace];
        sp += 2;
      end
    end
    if (expected_codes.size() > first_idx)
      expected_codes[expected_codes.size()-1].fin = 1'b1;
    n_loaded = 0;
    heap_n = 0;
  endfunction

  task automatic send_word(logic [7:0] sym, logic [15:0] w, logic lst);
    int idle;
    idle = $urandom_range(0, 3);
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    symbol_i <= sym;
    weight_i <= w;
    last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
    predict_codes(sym, w, lst);
    @(negedge clk_i);
  endtask

  // output stall: new draw per result word
  always @(negedge clk_i) begin
    if (!sink_busy) begin
      sink_busy = 1'b1;
      fork begin
        int stall;
        stall = $urandom_range(0, 3);
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        sink_busy = 1'b0;
      end join_none
    end
  end

  always @(posedge clk_i) begin
    code_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        $error("unexpected code word for symbol %0d", out_symbol_o);
        err_cnt++;
      end else begin
        exp_w = expected_codes.pop_front();
        if (out_symbol_o !== exp_w.sym) begin
          $error("out_symbol exp %0d got %0d", exp_w.sym, out_symbol_o); err_cnt++;
        end
        if (code_bits_o !== exp_w.bits) begin
          $error("code_bits exp %h got %h", exp_w.bits, code_bits_o); err_cnt++;
        end
        if (code_length_o !== exp_w.len) begin
          $error("code_length exp %0d got %0d", exp_w.len, code_length_o); err_cnt++;
        end
        if (final_code_o !== exp_w.fin) begin
          $error("final_code exp %0d got %0d", exp_w.fin, final_code_o); err_cnt++;
        end
      end
    end
  end

  task automatic send_alphabet(int n, int wmax);
    for (int i = 0; i < n; i++)
      send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, wmax)), i == n - 1);
  endtask

  task automatic test_single_symbol();
    send_word(8'hff, 16'hffff, 1'b1);
    send_word(8'h00, 16'h0000, 1'b1);
  endtask

  task automatic test_extremes();
    send_word(8'h00, 16'h0000, 1'b0);
    send_word(8'hff, 16'hffff, 1'b0);
    send_word(8'h55, 16'h0000, 1'b0);
    send_word(8'haa, 16'hffff, 1'b1);
    send_word(8'h01, 16'h0005, 1'b0);
    send_word(8'h02, 16'h0005, 1'b0);
    send_word(8'h03, 16'h0005, 1'b1);
  endtask

  // fibonacci weights give a maximally deep tree
  task automatic test_deep_tree();
    int f0;
    int f1;
    int t;
    f0 = 1;
    f1 = 1;
    for (int i = 0; i < 12; i++) begin
      send_word(8'(i + 16), 16'(f0), i == 11);
      t = f0 + f1;
      f0 = f1;
      f1 = t;
    end
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 66; i++)
      send_word(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), i == 65);
  endtask

  task automatic test_random();
    int sent;
    int n;
    sent = 0;
    while (sent < 72) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 10);
      if (n > 72 - sent) n = 72 - sent;
      send_alphabet(n, ($urandom_range(0, 1) == 0) ? 7 : 65535);
      sent += n;
    end
  endtask

  initial begin
    int guard;
    clk_i = 1'b0;
    err_cnt = 0;
    n_loaded = 0;
    heap_n = 0;
    sink_busy = 1'b1;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    symbol_i = '0;
    weight_i = '0;
    last_i = 1'b0;
    out_ready_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    sink_busy = 1'b0;
    test_single_symbol();
    test_extremes();
    test_deep_tree();
    test_overflow();
    test_random();
    in_valid_i <= 1'b0;
    guard = 0;
    while (expected_codes.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && expected_codes.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
